>>> rtl/stepper_speed_ramp_position_assert.svh
// Assertion macros for the checker file ssrp_check.sv.
// Each expects clk and rst_n in scope.
`ifndef STEPPER_SPEED_RAMP_POSITION_ASSERT_SVH
`define STEPPER_SPEED_RAMP_POSITION_ASSERT_SVH

// Same-cycle implication.
`define SSRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssrp check failed");

// Next-cycle implication.
`define SSRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssrp check failed");

`endif

>>> rtl/ssrp_pkg.sv
`default_nettype none

package ssrp_pkg;

    localparam int FREQ_WIDTH     = 24;
    localparam int FREQ_FRAC_BITS = 8;
    localparam int POS_WIDTH      = 32;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int CFG_IDX_WIDTH  = 3;

    typedef logic [FREQ_WIDTH-1:0] freq_t;
    typedef logic signed [POS_WIDTH-1:0] pos_t;
    typedef logic signed [POS_WIDTH:0] pos_ext_t;

    localparam freq_t FREQ_MAX = {FREQ_WIDTH{1'b1}};
    localparam freq_t FREQ_ZERO = {FREQ_WIDTH{1'b0}};

    // 1.0 Hz and roughly 2/3 Hz in the fixed-point frequency format
    localparam longint RAMP_STEP_RST_L = (64'd1 << FREQ_FRAC_BITS);
    localparam longint MIN_FREQ_RST_L  = ((64'd2 << FREQ_FRAC_BITS) + 64'd1) / 64'd3;
    localparam freq_t RAMP_STEP_RST = RAMP_STEP_RST_L[FREQ_WIDTH-1:0];
    localparam freq_t MIN_FREQ_RST  = MIN_FREQ_RST_L[FREQ_WIDTH-1:0];

    localparam pos_t MAX_POS_RST = 32'sd100000000;
    localparam pos_t MIN_POS_RST = -32'sd100000000;

    localparam pos_ext_t POS_WRAP_HI = 33'sd2000000000;
    localparam pos_ext_t POS_WRAP_LO = -33'sd2000000000;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_STEP    = 3'd1,
        ACT_START   = 3'd2,
        ACT_TARGET  = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_DIR     = 3'd5,
        ACT_SET_POS = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        MOTOR_STOPPED = 2'd0,
        MOTOR_ACCEL   = 2'd1,
        MOTOR_CRUISE  = 2'd2,
        MOTOR_DECEL   = 2'd3
    } motor_state_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_RAMP_UP   = 3'd0,
        CFG_RAMP_DOWN = 3'd1,
        CFG_MIN_FREQ  = 3'd2,
        CFG_MAX_POS   = 3'd3,
        CFG_MIN_POS   = 3'd4,
        CFG_MAX_EN    = 3'd5,
        CFG_MIN_EN    = 3'd6,
        CFG_INVERT    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        freq_t ramp_up_step;
        freq_t ramp_down_step;
        freq_t min_freq;
        pos_t  max_position;
        pos_t  min_position;
        logic  max_limit_enable;
        logic  min_limit_enable;
        logic  invert_direction;
    } cfg_t;

    typedef struct packed {
        action_t action;
        freq_t   freq_value;
        logic    new_direction;
        logic    force_direction;
        pos_t    position_value;
    } item_t;

    typedef struct packed {
        motor_state_t motor_state;
        freq_t        current_freq;
        freq_t        target_out;
        pos_t         position_low;
        pos_t         position_high;
        logic         direction_pin;
        logic         step_emitted;
        logic         accepted;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/ssrp_cfg.sv
`default_nettype none

module ssrp_cfg (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [ssrp_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  wire logic [ssrp_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    output ssrp_pkg::cfg_t                              cfg
);

    ssrp_pkg::cfg_t cfg_reg;
    ssrp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                ssrp_pkg::CFG_RAMP_UP:
                    cfg_next.ramp_up_step = cfg_data[ssrp_pkg::FREQ_WIDTH-1:0];
                ssrp_pkg::CFG_RAMP_DOWN:
                    cfg_next.ramp_down_step = cfg_data[ssrp_pkg::FREQ_WIDTH-1:0];
                ssrp_pkg::CFG_MIN_FREQ:
                    cfg_next.min_freq = cfg_data[ssrp_pkg::FREQ_WIDTH-1:0];
                ssrp_pkg::CFG_MAX_POS:
                    cfg_next.max_position = ssrp_pkg::pos_t'(cfg_data[ssrp_pkg::POS_WIDTH-1:0]);
                ssrp_pkg::CFG_MIN_POS:
                    cfg_next.min_position = ssrp_pkg::pos_t'(cfg_data[ssrp_pkg::POS_WIDTH-1:0]);
                ssrp_pkg::CFG_MAX_EN:
                    cfg_next.max_limit_enable = cfg_data[0];
                ssrp_pkg::CFG_MIN_EN:
                    cfg_next.min_limit_enable = cfg_data[0];
                ssrp_pkg::CFG_INVERT:
                    cfg_next.invert_direction = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_up_step     <= ssrp_pkg::RAMP_STEP_RST;
            cfg_reg.ramp_down_step   <= ssrp_pkg::RAMP_STEP_RST;
            cfg_reg.min_freq         <= ssrp_pkg::MIN_FREQ_RST;
            cfg_reg.max_position     <= ssrp_pkg::MAX_POS_RST;
            cfg_reg.min_position     <= ssrp_pkg::MIN_POS_RST;
            cfg_reg.max_limit_enable <= 1'b0;
            cfg_reg.min_limit_enable <= 1'b0;
            cfg_reg.invert_direction <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/ssrp_exec.sv
`default_nettype none

module ssrp_exec (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire ssrp_pkg::item_t      item,
    input  wire ssrp_pkg::cfg_t       cfg,
    output ssrp_pkg::result_t         result
);

    ssrp_pkg::motor_state_t state_reg, state_next;
    ssrp_pkg::freq_t        freq_now_reg, freq_now_next;
    ssrp_pkg::freq_t        freq_target_reg, freq_target_next;
    logic                   dir_reg, dir_next;
    ssrp_pkg::pos_t         pos_count_reg, pos_count_next;
    ssrp_pkg::pos_t         pos_wraps_reg, pos_wraps_next;

    logic [ssrp_pkg::FREQ_WIDTH:0] up_sum;
    ssrp_pkg::freq_t   up_sat, up_lo, up_f;
    ssrp_pkg::freq_t   dn_raw, dn_f;
    ssrp_pkg::freq_t   start_cap, start_f;
    ssrp_pkg::pos_ext_t pos_ext, pos_inc, pos_dec, pos_step;
    ssrp_pkg::pos_ext_t max_ext, min_ext;
    logic              wrap_up, wrap_down, limit_hit;
    logic              accepted, stepped;

    // Frequency datapath for tick and start
    always_comb
    begin
        up_sum = {1'b0, freq_now_reg} + {1'b0, cfg.ramp_up_step};
        up_sat = up_sum[ssrp_pkg::FREQ_WIDTH] ? ssrp_pkg::FREQ_MAX
                                               : up_sum[ssrp_pkg::FREQ_WIDTH-1:0];
        up_lo  = (up_sat < cfg.min_freq) ? cfg.min_freq : up_sat;
        up_f   = (up_lo > freq_target_reg) ? freq_target_reg : up_lo;

        dn_raw = (freq_now_reg > cfg.ramp_down_step) ? freq_now_reg - cfg.ramp_down_step
                                                     : ssrp_pkg::FREQ_ZERO;
        dn_f   = (dn_raw < freq_target_reg) ? freq_target_reg : dn_raw;

        // Start caps at the target first, then raises to the floor
        start_cap = (cfg.ramp_up_step > freq_target_reg) ? freq_target_reg
                                                         : cfg.ramp_up_step;
        start_f   = (start_cap < cfg.min_freq) ? cfg.min_freq : start_cap;
    end

    // Position datapath for a step pulse
    always_comb
    begin
        pos_ext = {pos_count_reg[ssrp_pkg::POS_WIDTH-1], pos_count_reg};
        max_ext = {cfg.max_position[ssrp_pkg::POS_WIDTH-1], cfg.max_position};
        min_ext = {cfg.min_position[ssrp_pkg::POS_WIDTH-1], cfg.min_position};
        pos_inc = pos_ext + 33'sd1;
        pos_dec = pos_ext - 33'sd1;
        wrap_up   = pos_inc > ssrp_pkg::POS_WRAP_HI;
        wrap_down = pos_dec < ssrp_pkg::POS_WRAP_LO;
        if (dir_reg)
        begin
            pos_step  = wrap_up ? '0 : pos_inc;
            limit_hit = cfg.max_limit_enable && (pos_step >= max_ext);
        end
        else
        begin
            pos_step  = wrap_down ? '0 : pos_dec;
            limit_hit = cfg.min_limit_enable && (pos_step <= min_ext);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        freq_now_next    = freq_now_reg;
        freq_target_next = freq_target_reg;
        dir_next         = dir_reg;
        pos_count_next   = pos_count_reg;
        pos_wraps_next   = pos_wraps_reg;
        accepted         = 1'b0;
        stepped          = 1'b0;

        unique case (item.action)
            ssrp_pkg::ACT_TICK:
            begin
                if (state_reg != ssrp_pkg::MOTOR_STOPPED)
                begin
                    accepted = 1'b1;
                    if (freq_now_reg < freq_target_reg)
                    begin
                        freq_now_next = up_f;
                        state_next    = ssrp_pkg::MOTOR_ACCEL;
                    end
                    else if (freq_now_reg > freq_target_reg)
                    begin
                        // Dropping under the floor ends the run
                        if (dn_f < cfg.min_freq)
                        begin
                            freq_now_next = ssrp_pkg::FREQ_ZERO;
                            state_next    = ssrp_pkg::MOTOR_STOPPED;
                        end
                        else
                        begin
                            freq_now_next = dn_f;
                            state_next    = ssrp_pkg::MOTOR_DECEL;
                        end
                    end
                    else
                    begin
                        state_next = (freq_now_reg == ssrp_pkg::FREQ_ZERO)
                                   ? ssrp_pkg::MOTOR_STOPPED : ssrp_pkg::MOTOR_CRUISE;
                    end
                end
            end
            ssrp_pkg::ACT_STEP:
            begin
                if (state_reg != ssrp_pkg::MOTOR_STOPPED)
                begin
                    accepted       = 1'b1;
                    stepped        = 1'b1;
                    pos_count_next = pos_step[ssrp_pkg::POS_WIDTH-1:0];
                    if (dir_reg && wrap_up)
                        pos_wraps_next = pos_wraps_reg + 32'sd1;
                    else if (!dir_reg && wrap_down)
                        pos_wraps_next = pos_wraps_reg - 32'sd1;
                    if (limit_hit)
                        freq_target_next = ssrp_pkg::FREQ_ZERO;
                end
            end
            ssrp_pkg::ACT_START:
            begin
                if (state_reg == ssrp_pkg::MOTOR_STOPPED
                    && freq_target_reg != ssrp_pkg::FREQ_ZERO)
                begin
                    accepted      = 1'b1;
                    freq_now_next = start_f;
                    state_next    = ssrp_pkg::MOTOR_ACCEL;
                end
            end
            ssrp_pkg::ACT_TARGET:
            begin
                accepted         = 1'b1;
                freq_target_next = item.freq_value;
            end
            ssrp_pkg::ACT_STOP:
            begin
                accepted         = 1'b1;
                freq_target_next = ssrp_pkg::FREQ_ZERO;
                freq_now_next    = ssrp_pkg::FREQ_ZERO;
                state_next       = ssrp_pkg::MOTOR_STOPPED;
            end
            ssrp_pkg::ACT_DIR:
            begin
                if (dir_reg == item.new_direction || item.force_direction)
                begin
                    accepted = 1'b1;
                    dir_next = item.new_direction;
                end
            end
            ssrp_pkg::ACT_SET_POS:
            begin
                accepted       = 1'b1;
                pos_count_next = item.position_value;
            end
            default:
            begin
                accepted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ssrp_pkg::MOTOR_STOPPED;
            freq_now_reg    <= ssrp_pkg::FREQ_ZERO;
            freq_target_reg <= ssrp_pkg::FREQ_ZERO;
            dir_reg         <= 1'b1;
            pos_count_reg   <= '0;
            pos_wraps_reg   <= '0;
        end
        else if (fire)
        begin
            state_reg       <= state_next;
            freq_now_reg    <= freq_now_next;
            freq_target_reg <= freq_target_next;
            dir_reg         <= dir_next;
            pos_count_reg   <= pos_count_next;
            pos_wraps_reg   <= pos_wraps_next;
        end
    end

    always_comb
    begin
        result.motor_state   = state_next;
        result.current_freq  = freq_now_next;
        result.target_out    = freq_target_next;
        result.position_low  = pos_count_next;
        result.position_high = pos_wraps_next;
        result.direction_pin = dir_next ^ cfg.invert_direction;
        result.step_emitted  = stepped;
        result.accepted      = accepted;
    end

endmodule

`default_nettype wire

>>> rtl/stepper_speed_ramp_position.sv
// Stepper speed-ramp controller with step position counting.
// Input channel (in_valid / in_stall) carries one command item: ramp tick,
// step pulse, start, set target, stop, set direction or set position.
// Output channel (out_valid / out_stall) returns exactly one result item per
// command: motor state, frequencies, position counts and flags after it.
// Configuration registers are written through cfg_write / cfg_index / cfg_data,
// one register per cycle; the user must write them only while no item is in flight (not enforced by the block).
// Path: an accepted item sits in the input register, then executes and lands
// in the output register, which drives out_valid and the result outputs.
// Throughput: one item per cycle while out_stall is low; the execute stage is an
// add or subtract with compares and clamps on the frequency and position registers.
// When out_stall holds a result, the input register absorbs one more item
// and in_stall then rises until the output drains.
// Reset (rst_n low, asynchronous) empties both registers, stops the motor,
// sets direction forward, zeroes position and restores configuration
// defaults.
`default_nettype none

module stepper_speed_ramp_position (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output      logic                                   in_stall,
    input  wire logic [2:0]                             action,
    input  wire logic [ssrp_pkg::FREQ_WIDTH-1:0]        freq_value,
    input  wire logic                                   new_direction,
    input  wire logic                                   force_direction,
    input  wire logic signed [ssrp_pkg::POS_WIDTH-1:0]  position_value,
    output      logic                                   out_valid,
    input  wire logic                                   out_stall,
    output      logic [1:0]                             motor_state,
    output      logic [ssrp_pkg::FREQ_WIDTH-1:0]        current_freq,
    output      logic [ssrp_pkg::FREQ_WIDTH-1:0]        target_out,
    output      logic signed [ssrp_pkg::POS_WIDTH-1:0]  position_low,
    output      logic signed [ssrp_pkg::POS_WIDTH-1:0]  position_high,
    output      logic                                   direction_pin,
    output      logic                                   step_emitted,
    output      logic                                   accepted,
    input  wire logic                                   cfg_write,
    input  wire logic [ssrp_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  wire logic [ssrp_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    ssrp_pkg::cfg_t    cfg;
    ssrp_pkg::item_t   item_reg, item_next;
    ssrp_pkg::result_t result;
    ssrp_pkg::result_t result_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              in_take;

    ssrp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssrp_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Execute when the output register is free or draining this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_next.action          = ssrp_pkg::action_t'(action);
        item_next.freq_value      = freq_value;
        item_next.new_direction   = new_direction;
        item_next.force_direction = force_direction;
        item_next.position_value  = position_value;

        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= item_next;
        if (advance)
            result_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign motor_state   = result_reg.motor_state;
    assign current_freq  = result_reg.current_freq;
    assign target_out    = result_reg.target_out;
    assign position_low  = result_reg.position_low;
    assign position_high = result_reg.position_high;
    assign direction_pin = result_reg.direction_pin;
    assign step_emitted  = result_reg.step_emitted;
    assign accepted      = result_reg.accepted;

endmodule

`default_nettype wire

>>> rtl/ssrp_check.sv
`default_nettype none

`include "stepper_speed_ramp_position_assert.svh"

module ssrp_check (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [1:0]                         motor_state,
    input wire logic [ssrp_pkg::FREQ_WIDTH-1:0]    current_freq,
    input wire logic                               step_emitted,
    input wire logic                               accepted
);

    logic stopped;

    assign stopped = (motor_state == ssrp_pkg::MOTOR_STOPPED);

    // A stalled item stays offered, with its frequency and motor state unchanged
    `SSRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `SSRP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(current_freq) && $stable(motor_state))

    // A counted step is always an accepted command issued while running
    `SSRP_ASSERT_NOW(a_step_accepted, out_valid && step_emitted, accepted)
    `SSRP_ASSERT_NOW(a_step_running, out_valid && step_emitted, !stopped)

    // A stopped motor never reports a nonzero frequency
    `SSRP_ASSERT_NOW(a_stop_zero, out_valid && stopped, current_freq == ssrp_pkg::FREQ_ZERO)

endmodule

bind stepper_speed_ramp_position ssrp_check u_ssrp_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .motor_state  (motor_state),
    .current_freq (current_freq),
    .step_emitted (step_emitted),
    .accepted     (accepted)
);

`default_nettype wire
